// File: design/ted_pkg.sv
// ============================================================================
// Text encoding detector package
// Shared types, constants and decode functions for the encoding detector.
// ============================================================================
package ted_pkg;

    typedef enum logic [1:0] {
        CLASS_ANSI     = 2'd0,
        CLASS_UTF16_LE = 2'd1,
        CLASS_UTF16_BE = 2'd2,
        CLASS_UTF8     = 2'd3
    } enc_class_t;

    localparam logic [15:0] MARK_UTF16_LE = 16'hFFFE;
    localparam logic [15:0] MARK_UTF16_BE = 16'hFEFF;
    localparam logic [15:0] MARK_UTF8     = 16'hEFBB;

    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_BODY   = 2'd2;

    typedef struct packed {
        logic [1:0] byte_position;
        logic [7:0] first_byte_seen;
        enc_class_t mark_class;
        logic [2:0] continuation_left;
        logic       only_ascii;
        logic       sequence_failed;
    } scan_state_t;

    localparam scan_state_t SCAN_RESET = '{
        byte_position:     POS_FIRST,
        first_byte_seen:   8'h00,
        mark_class:        CLASS_ANSI,
        continuation_left: 3'd0,
        only_ascii:        1'b1,
        sequence_failed:   1'b0
    };

    // continuation bytes owed after a lead byte; zero for a stray 80-BF
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        priority if (b == 8'hFC || b == 8'hFD) begin
            len = 3'd5;
        end else if (b >= 8'hF8) begin
            len = 3'd4;
        end else if (b >= 8'hF0) begin
            len = 3'd3;
        end else if (b >= 8'hE0) begin
            len = 3'd2;
        end else if (b >= 8'hC0) begin
            len = 3'd1;
        end else begin
            len = 3'd0;
        end
        return len;
    endfunction

    function automatic enc_class_t mark_of(input logic [7:0] b0, input logic [7:0] b1);
        enc_class_t cls;
        priority if ({b0, b1} == MARK_UTF16_LE) begin
            cls = CLASS_UTF16_LE;
        end else if ({b0, b1} == MARK_UTF16_BE) begin
            cls = CLASS_UTF16_BE;
        end else if ({b0, b1} == MARK_UTF8) begin
            cls = CLASS_UTF8;
        end else begin
            cls = CLASS_ANSI;
        end
        return cls;
    endfunction

endpackage

// File: design/ted_scan_step.sv
// ============================================================================
// Encoding detector scan step
// Next scan state and end-of-file class for one byte of the stream.
// ============================================================================
module ted_scan_step (
    input  ted_pkg::scan_state_t cur_state,
    input  logic [7:0]           data_byte,
    output ted_pkg::scan_state_t next_state,
    output ted_pkg::enc_class_t  file_class
);

    logic [2:0] lead_len;

    assign lead_len = ted_pkg::lead_length(data_byte);

    always_comb begin
        next_state = cur_state;

        unique case (cur_state.byte_position)
            ted_pkg::POS_FIRST: begin
                next_state.first_byte_seen = data_byte;
                next_state.byte_position   = ted_pkg::POS_SECOND;
            end
            ted_pkg::POS_SECOND: begin
                next_state.mark_class    = ted_pkg::mark_of(cur_state.first_byte_seen,
                                                            data_byte);
                next_state.byte_position = ted_pkg::POS_BODY;
            end
            default: begin
                next_state.byte_position = ted_pkg::POS_BODY;
            end
        endcase

        if (data_byte[7]) begin
            next_state.only_ascii = 1'b0;
        end

        if (!cur_state.sequence_failed) begin
            if (cur_state.continuation_left == 3'd0) begin
                if (data_byte[7]) begin
                    if (lead_len == 3'd0) begin
                        next_state.sequence_failed = 1'b1;
                    end else begin
                        next_state.continuation_left = lead_len;
                    end
                end
            end else begin
                if (data_byte[7:6] != 2'b10) begin
                    next_state.sequence_failed = 1'b1;
                end else begin
                    next_state.continuation_left = cur_state.continuation_left - 3'd1;
                end
            end
        end
    end

    always_comb begin
        priority if (next_state.mark_class != ted_pkg::CLASS_ANSI) begin
            file_class = next_state.mark_class;
        end else if (next_state.sequence_failed || next_state.continuation_left != 3'd0
                     || next_state.only_ascii) begin
            file_class = ted_pkg::CLASS_ANSI;
        end else begin
            file_class = ted_pkg::CLASS_UTF8;
        end
    end

endmodule

// File: design/text_encoding_detector_core.sv
// ============================================================================
// Text encoding detector core
// Classifies a byte stream as ANSI, UTF-16 LE/BE (by mark) or UTF-8.
// ============================================================================
//  channel  | dir | tdata                  | tlast
//  s_       | in  | [7:0] data_byte        | last_byte
//  m_       | out | [1:0] encoding_class   | -
//
//  One byte per clock, sustained unless a last byte waits on a result. A byte
//  is held in an input register, then the scan step updates the state and,
//  on the last byte, loads the result register.
//  Reset is synchronous, active low; no clearing pass.
//  A waiting result stalls only a last byte; other bytes keep flowing.
// ============================================================================
module text_encoding_detector_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [1:0] encoding_class, [7:2] zero
);

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 in_last_reg;
    ted_pkg::scan_state_t state_reg;
    ted_pkg::scan_state_t state_next;
    ted_pkg::enc_class_t  class_next;
    logic                 out_valid_reg;
    ted_pkg::enc_class_t  out_class_reg;
    logic                 advance;

    ted_scan_step u_scan (
        .cur_state  (state_reg),
        .data_byte  (in_byte_reg),
        .next_state (state_next),
        .file_class (class_next)
    );

    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ted_pkg::SCAN_RESET;
        end else if (advance) begin
            state_reg <= in_last_reg ? ted_pkg::SCAN_RESET : state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            out_class_reg <= class_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b000000, out_class_reg};

    // a new result only follows a last byte leaving the input register
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(advance && in_last_reg))
        else $error("result without a last byte");

    // state is back at reset after every file
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_last_reg) |=> (state_reg == ted_pkg::SCAN_RESET))
        else $error("scan state not cleared after file");

    // an open sequence implies a non-ASCII byte has been seen
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.continuation_left != 3'd0) |-> !state_reg.only_ascii)
        else $error("open sequence in an ASCII-only stream");

    // a mark is only recorded once two bytes have been taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.mark_class != ted_pkg::CLASS_ANSI) |->
            (state_reg.byte_position == ted_pkg::POS_BODY))
        else $error("mark recorded before second byte");

endmodule
